FILE: src/i2c_master_bitbang_controller_top_macros.svh
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BITBANG_CONTROLLER_TOP_MACROS_SVH
`define I2C_MASTER_BITBANG_CONTROLLER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define I2CM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define I2CM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/i2cm_pkg.sv
// Package with types and constants of the bit-banged I2C master.
package i2cm_pkg;

  localparam int unsigned BufDepthDefault = 8;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_BEGIN = 3'd1,
    KIND_QUEUE = 3'd2,
    KIND_END   = 3'd3,
    KIND_REQ   = 3'd4,
    KIND_POP   = 3'd5
  } kind_e_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_W = 4'd1,
    PH_START_R = 4'd2,
    PH_WBIT_AW = 4'd3,
    PH_WACK_AW = 4'd4,
    PH_WBIT_AR = 4'd5,
    PH_WACK_AR = 4'd6,
    PH_WBIT_D  = 4'd7,
    PH_WACK_D  = 4'd8,
    PH_RBIT    = 4'd9,
    PH_RACK    = 4'd10,
    PH_STOP    = 4'd11
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] address;
    logic [7:0] data;
    logic [3:0] count;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       rejected;
  } out_word_t;

  // Classified word passed from the front to the back.
  typedef struct packed {
    logic       is_tick;
    logic       is_cmd;
    logic [2:0] kind;
    logic [6:0] address;
    logic [7:0] data;
    logic [3:0] count;
    logic       sda_in;
  } cmd_word_t;

endpackage

FILE: src/i2cm_front.sv
// Front stage: accepts input words, classifies them and queues them.
module i2cm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2cm_pkg::in_word_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output i2cm_pkg::cmd_word_t q_word
);
  import i2cm_pkg::*;

  // Two-entry queue; stall only when both slots hold words.
  cmd_word_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_word_t  cls;
  logic       push;

  // Classification of the incoming word.
  always_comb begin
    cls.is_tick = (in_data.kind == KIND_TICK);
    cls.is_cmd  = (in_data.kind != KIND_TICK) && (in_data.kind <= KIND_POP);
    cls.kind    = in_data.kind;
    cls.address = in_data.address;
    cls.data    = in_data.data;
    cls.count   = in_data.count;
    cls.sda_in  = in_data.sda_in;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end
endmodule

FILE: src/i2cm_back.sv
// Back stage: bus sequencer, buffers and output register.
module i2cm_back #(
  parameter int unsigned BUFFER_DEPTH = i2cm_pkg::BufDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  i2cm_pkg::cmd_word_t q_word,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_word_t out_data
);
  import i2cm_pkg::*;

  localparam int unsigned IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [CW-1:0] txf_r, txf_nxt, rxf_r, rxf_nxt, rxn_r, rxn_nxt;
  logic [7:0]  txs_r, txs_nxt;
  logic [7:0]  lastp_r, lastp_nxt;
  logic [2:0]  pins_r, pins_nxt;
  logic [7:0]  tx_mem [BUFFER_DEPTH];
  logic [7:0]  rx_mem [BUFFER_DEPTH];
  logic        tx_we, rx_we;
  logic [IW-1:0] tx_wa, rx_wa;
  logic [7:0]  rx_wd;
  logic        ovalid_r;
  out_word_t   odata_r, odata_nxt;
  logic        take;
  logic [CW-1:0] cnt_c, txs_inc;
  logic        ack_a;

  assign take      = q_valid && (!ovalid_r || !out_stall);
  assign q_pop     = take;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign txs_inc   = txs_r[CW-1:0] + CW'(1);

  // One word of sequencing per accepted item.
  always_comb begin
    phase_nxt = phase_r; step_nxt = step_r; bits_nxt = bits_r; shift_nxt = shift_r;
    txf_nxt = txf_r; txs_nxt = txs_r; rxf_nxt = rxf_r; rxn_nxt = rxn_r;
    lastp_nxt = lastp_r; pins_nxt = pins_r;
    tx_we = 1'b0; tx_wa = txf_r[IW-1:0];
    rx_we = 1'b0; rx_wa = rxn_r[IW-1:0]; rx_wd = 8'h00;
    odata_nxt = '0;
    cnt_c = CW'(0); ack_a = 1'b0;
    if (q_word.count == 4'd0) cnt_c = CW'(1);
    else if (int'(q_word.count) > int'(BUFFER_DEPTH)) cnt_c = DEPTH_C;
    else cnt_c = CW'(q_word.count);
    if (q_word.is_tick && phase_r != PH_IDLE) begin
      case (phase_r)
        PH_START_W, PH_START_R: begin
          pins_nxt = (step_r == 2'd0) ? 3'b111 : (step_r == 2'd1) ? 3'b101 : 3'b100;
          if (step_r >= 2'd2) begin
            phase_nxt = (phase_r == PH_START_W) ? PH_WBIT_AW : PH_WBIT_AR;
            step_nxt = 2'd0; bits_nxt = 4'd0; shift_nxt = txs_r;
          end else begin
            step_nxt = step_r + 2'd1;
          end
        end
        PH_WBIT_AW, PH_WBIT_AR, PH_WBIT_D: begin
          pins_nxt = {1'b1, shift_r[7], step_r[0]};
          if (step_r == 2'd0) begin
            step_nxt = 2'd1;
          end else begin
            step_nxt = 2'd0; shift_nxt = {shift_r[6:0], 1'b0};
            bits_nxt = bits_r + 4'd1;
            if (bits_r == 4'd7) begin
              bits_nxt = 4'd0; phase_nxt = phase_t'(phase_r + 4'd1);
            end
          end
        end
        PH_WACK_AW, PH_WACK_AR, PH_WACK_D: begin
          pins_nxt = {1'b0, 1'b1, step_r[0]};
          if (step_r == 2'd0) begin
            step_nxt = 2'd1;
          end else if (phase_r == PH_WACK_AW) begin
            phase_nxt = PH_IDLE; step_nxt = 2'd0; txs_nxt = 8'h00; pins_nxt = 3'b110;
          end else if (phase_r == PH_WACK_AR) begin
            txs_nxt = 8'h00; phase_nxt = PH_RBIT; step_nxt = 2'd0;
            bits_nxt = 4'd0; shift_nxt = 8'h00;
          end else begin
            txs_nxt = 8'(txs_inc);
            if (txs_inc < txf_r && txs_inc < DEPTH_C) begin
              phase_nxt = PH_WBIT_D; step_nxt = 2'd0; bits_nxt = 4'd0;
              shift_nxt = tx_mem[txs_inc[IW-1:0]];
            end else begin
              phase_nxt = PH_STOP; step_nxt = 2'd0;
            end
          end
        end
        PH_RBIT: begin
          pins_nxt = {1'b0, 1'b1, step_r[0]};
          if (step_r == 2'd0) begin
            step_nxt = 2'd1;
          end else begin
            step_nxt = 2'd0; shift_nxt = {shift_r[6:0], q_word.sda_in};
            bits_nxt = bits_r + 4'd1;
            if (bits_r == 4'd7) begin
              bits_nxt = 4'd0;
              if (rxn_r < DEPTH_C) begin
                rx_we = 1'b1; rx_wd = {shift_r[6:0], q_word.sda_in};
              end
              rxn_nxt = rxn_r + CW'(1);
              phase_nxt = PH_RACK;
            end
          end
        end
        PH_RACK: begin
          ack_a = !(rxn_r < rxf_r);
          pins_nxt = {1'b1, ack_a, step_r == 2'd2};
          if (step_r < 2'd3) begin
            step_nxt = step_r + 2'd1;
          end else if (!ack_a) begin
            phase_nxt = PH_RBIT; step_nxt = 2'd0; bits_nxt = 4'd0; shift_nxt = 8'h00;
          end else begin
            rxn_nxt = CW'(0); phase_nxt = PH_STOP; step_nxt = 2'd0;
          end
        end
        PH_STOP: begin
          pins_nxt = (step_r == 2'd0) ? 3'b100 : (step_r == 2'd1) ? 3'b101 : 3'b111;
          if (step_r >= 2'd2) begin
            phase_nxt = PH_IDLE; step_nxt = 2'd0;
          end else begin
            step_nxt = step_r + 2'd1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE; step_nxt = 2'd0;
        end
      endcase
    end else if (q_word.is_cmd) begin
      if (phase_r != PH_IDLE) begin
        odata_nxt.rejected = 1'b1;
      end else begin
        case (q_word.kind)
          KIND_BEGIN: begin
            txf_nxt = CW'(0); txs_nxt = {q_word.address, 1'b0};
            phase_nxt = PH_START_W; step_nxt = 2'd0;
          end
          KIND_QUEUE: begin
            if (txf_r < DEPTH_C) begin
              tx_we = 1'b1; txf_nxt = txf_r + CW'(1);
            end
          end
          KIND_END: begin
            txs_nxt = 8'h00; step_nxt = 2'd0;
            if (txf_r != CW'(0)) begin
              phase_nxt = PH_WBIT_D; bits_nxt = 4'd0; shift_nxt = tx_mem[0];
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          KIND_REQ: begin
            rxf_nxt = cnt_c; rxn_nxt = CW'(0);
            txs_nxt = {q_word.address, 1'b1};
            phase_nxt = PH_START_R; step_nxt = 2'd0;
          end
          KIND_POP: begin
            if (rxn_r < rxf_r) begin
              lastp_nxt = rx_mem[rxn_r[IW-1:0]]; rxn_nxt = rxn_r + CW'(1);
            end
            odata_nxt.read_data = lastp_nxt; odata_nxt.read_valid = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
    odata_nxt.scl       = pins_nxt[0];
    odata_nxt.sda_out   = pins_nxt[2] ? pins_nxt[1] : 1'b1;
    odata_nxt.sda_drive = pins_nxt[2];
    odata_nxt.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; step_r <= 2'd0; bits_r <= 4'd0; shift_r <= 8'h00;
      txf_r <= '0; txs_r <= 8'h00; rxf_r <= '0; rxn_r <= '0;
      lastp_r <= 8'h00; pins_r <= 3'b111; ovalid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; step_r <= step_nxt; bits_r <= bits_nxt;
        shift_r <= shift_nxt; txf_r <= txf_nxt; txs_r <= txs_nxt;
        rxf_r <= rxf_nxt; rxn_r <= rxn_nxt; lastp_r <= lastp_nxt; pins_r <= pins_nxt;
      end
      if (take) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  // Output register and buffer writes.
  always_ff @(posedge clk) begin
    if (take) odata_r <= odata_nxt;
    if (take && tx_we) tx_mem[tx_wa] <= q_word.data;
    if (take && rx_we) rx_mem[rx_wa] <= rx_wd;
  end
endmodule

FILE: src/i2c_master_bitbang_controller_top.sv
// Inputs pass the front queue; each result is registered in the back stage.
// Throughput: one word per cycle while not stalled, one sequencer step per word.
// A two-entry queue between front and back holds words while the output stalls.
// Reset is synchronous, active low: bus idle, SCL and SDA high and driven.
// Buffer contents are not cleared by reset.
module i2c_master_bitbang_controller_top #(
  parameter int unsigned BUFFER_DEPTH = i2cm_pkg::BufDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_word_t out_data
);
  import i2cm_pkg::*;

  logic      q_valid, q_pop;
  cmd_word_t q_word;

  i2cm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
  );

  i2cm_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule

FILE: src/i2cm_checker.sv
// Port-level checker for the I2C master and its bind statement.
`include "i2c_master_bitbang_controller_top_macros.svh"
module i2cm_port_props (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input i2cm_pkg::out_word_t out_data
);
  import i2cm_pkg::*;

  `I2CM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `I2CM_ASSERT_IMP(a_released_high, out_valid && !out_data.sda_drive, out_data.sda_out)
  `I2CM_ASSERT_IMP(a_pop_not_rej, out_valid && out_data.read_valid, !out_data.rejected)
  `I2CM_ASSERT_IMP(a_data_zero, out_valid && !out_data.read_valid, out_data.read_data == 8'h00)
endmodule

bind i2c_master_bitbang_controller_top i2cm_port_props u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
